// ===== rtl/pip_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants for the ray-casting point-in-polygon unit.
// ----------------------------------------------------------------------------
package pip_pkg;

	// Width of the coordinate ports
	localparam int PORT_BITS  = 32;
	// Low bits of each coordinate that take part in the test (8..32)
	localparam int COORD_BITS = 32;
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int PROD_BITS  = 2 * DIFF_BITS;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_BITS-1:0]  diff_t;
	typedef logic signed [PROD_BITS-1:0]  prod_t;

	// Outcome of one edge test
	typedef struct packed {
		logic hit;   // point on the edge or its end vertex, or level with a horizontal edge and not left of it
		logic flip;  // ray crosses the edge: toggle parity
	} edge_res_t;

	// Take the low COORD_BITS of a port value as two's complement
	function automatic coord_t coord_of(input logic [PORT_BITS-1:0] raw);
		coord_of = coord_t'(raw[COORD_BITS-1:0]);
	endfunction

endpackage

// ===== rtl/pip_edge_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_edge_test
// Exact integer ray-crossing test of one edge (j -> i) against a point.
// Products and compare flags are registered on load; the verdict is
// formed from those registers.
// ----------------------------------------------------------------------------
module pip_edge_test (
	input  logic                  clk,
	input  logic                  load,
	input  pip_pkg::coord_t       ix,
	input  pip_pkg::coord_t       iy,
	input  pip_pkg::coord_t       jx,
	input  pip_pkg::coord_t       jy,
	input  pip_pkg::coord_t       px,
	input  pip_pkg::coord_t       py,
	output pip_pkg::edge_res_t    res
);

	pip_pkg::diff_t dix, diy, djx, djy;
	logic           pre_hit, straddle, i_below;

	pip_pkg::prod_t prod_a_s2, prod_b_s2;
	logic           pre_hit_s2, straddle_s2, i_below_s2;
	logic           gt, eq;

	// Offsets from the point, exact in one extra bit
	assign dix = pip_pkg::diff_t'(ix) - pip_pkg::diff_t'(px);
	assign diy = pip_pkg::diff_t'(iy) - pip_pkg::diff_t'(py);
	assign djx = pip_pkg::diff_t'(jx) - pip_pkg::diff_t'(px);
	assign djy = pip_pkg::diff_t'(jy) - pip_pkg::diff_t'(py);

	// Vertex hit, or point level with a horizontal edge and not left of it
	assign pre_hit  = (iy == py) && ((ix == px) || ((jy == py) && ((ix <= px) || (jx <= px))));
	assign straddle = (py < iy) != (py < jy);
	assign i_below  = iy < jy;

	// Register the cross-product terms and flags
	always_ff @(posedge clk) begin
		if (load) begin
			prod_a_s2   <= pip_pkg::prod_t'(dix) * pip_pkg::prod_t'(djy);
			prod_b_s2   <= pip_pkg::prod_t'(diy) * pip_pkg::prod_t'(djx);
			pre_hit_s2  <= pre_hit;
			straddle_s2 <= straddle;
			i_below_s2  <= i_below;
		end
	end

	// Sign of the cross product decides crossing or collinear hit
	assign gt = prod_a_s2 > prod_b_s2;
	assign eq = prod_a_s2 == prod_b_s2;

	assign res.hit  = pre_hit_s2 || (straddle_s2 && eq);
	assign res.flip = !pre_hit_s2 && straddle_s2 && !eq && (gt != i_below_s2);

endmodule

// ===== rtl/point_in_polygon_ray_cast_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_ray_cast_unit
// Crossing-number point-in-polygon test over a stream of vertices.
//
//   Channel   Handshake              Payload
//   --------  ---------------------  --------------------------------------
//   input     in_valid / in_ready    point_x point_y vertex_x vertex_y
//                                    first_vertex last_vertex
//   result    out_valid / out_ready  inside_res
//   config    cfg_valid / cfg_ready  boundary_inside
//
// One vertex item per cycle unless a last item holds in the product stage.
// A result passes the input, product and result registers, with the two
// 33x33 cross-product multiplies of each edge test in the
// second stage. Reset clears the pipeline, parity, hit flag, start and
// prior vertex, and sets boundary_inside to 1. Non-last items keep flowing
// while a result waits; a last item holds in the product stage until the
// result register is free. Config writes are taken every cycle.
// ----------------------------------------------------------------------------
module point_in_polygon_ray_cast_unit (
	input  logic                             clk,
	input  logic                             arst_n,

	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [pip_pkg::PORT_BITS-1:0]    point_x,
	input  logic [pip_pkg::PORT_BITS-1:0]    point_y,
	input  logic [pip_pkg::PORT_BITS-1:0]    vertex_x,
	input  logic [pip_pkg::PORT_BITS-1:0]    vertex_y,
	input  logic                             first_vertex,
	input  logic                             last_vertex,

	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             inside_res,

	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic                             boundary_inside
);

	pip_pkg::coord_t    px, py, vx, vy;
	pip_pkg::coord_t    start_x_q, start_y_q, prior_x_q, prior_y_q;
	pip_pkg::coord_t    px_s1, py_s1, vx_s1, vy_s1, jx_s1, jy_s1, sx_s1, sy_s1;
	logic               valid_s1, first_s1, last_s1;
	logic               valid_s2, first_s2, last_s2;
	logic               parity_q, hit_q, edge_in_q, res_q, out_valid_q;
	logic               in_go, s1_go, s2_go, s2_ready, out_free;
	logic               par_new, hit_new;
	pip_pkg::edge_res_t open_res, close_res;

	assign px = pip_pkg::coord_of(point_x);
	assign py = pip_pkg::coord_of(point_y);
	assign vx = pip_pkg::coord_of(vertex_x);
	assign vy = pip_pkg::coord_of(vertex_y);

	// Stage flow: only a last item needs room in the result register
	assign out_free = !out_valid_q || out_ready;
	assign s2_go    = valid_s2 && (!last_s2 || out_free);
	assign s2_ready = !valid_s2 || s2_go;
	assign s1_go    = valid_s1 && s2_ready;
	assign in_ready = !valid_s1 || s2_ready;
	assign in_go    = in_valid && in_ready;

	// Configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_in_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			edge_in_q <= boundary_inside;
		end
	end

	// Track start and prior vertex as items arrive
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			prior_x_q <= '0;
			prior_y_q <= '0;
		end else if (in_go) begin
			if (first_vertex) begin
				start_x_q <= vx;
				start_y_q <= vy;
			end
			prior_x_q <= vx;
			prior_y_q <= vy;
		end
	end

	// Input register: item plus the vertices its edges need
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_go) begin
			px_s1    <= px;
			py_s1    <= py;
			vx_s1    <= vx;
			vy_s1    <= vy;
			jx_s1    <= prior_x_q;
			jy_s1    <= prior_y_q;
			sx_s1    <= first_vertex ? vx : start_x_q;
			sy_s1    <= first_vertex ? vy : start_y_q;
			first_s1 <= first_vertex;
			last_s1  <= last_vertex;
		end
	end

	// Edge from prior vertex to this one
	pip_edge_test u_open (
		.clk  (clk),
		.load (s1_go),
		.ix   (vx_s1),
		.iy   (vy_s1),
		.jx   (jx_s1),
		.jy   (jy_s1),
		.px   (px_s1),
		.py   (py_s1),
		.res  (open_res)
	);

	// Closing edge from this vertex back to the start
	pip_edge_test u_close (
		.clk  (clk),
		.load (s1_go),
		.ix   (sx_s1),
		.iy   (sy_s1),
		.jx   (vx_s1),
		.jy   (vy_s1),
		.px   (px_s1),
		.py   (py_s1),
		.res  (close_res)
	);

	// Product stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			first_s2 <= first_s1;
			last_s2  <= last_s1;
		end
	end

	// Fold both edge verdicts into parity and hit
	always_comb begin
		par_new = first_s2 ? 1'b0 : parity_q;
		hit_new = first_s2 ? 1'b0 : hit_q;
		if (!first_s2) begin
			par_new = par_new ^ open_res.flip;
			hit_new = hit_new | open_res.hit;
		end
		if (last_s2) begin
			par_new = par_new ^ close_res.flip;
			hit_new = hit_new | close_res.hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q <= 1'b0;
			hit_q    <= 1'b0;
		end else if (s2_go) begin
			parity_q <= par_new;
			hit_q    <= hit_new;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_go && last_s2) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go && last_s2) begin
			res_q <= hit_new ? edge_in_q : par_new;
		end
	end

	assign out_valid  = out_valid_q;
	assign inside_res = res_q;

`ifndef SYNTH
	// A finished last item always lands in the result register
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		s2_go && last_s2 |=> out_valid)
		else $error("last item did not produce a result");

	// Items without a result never stall in the product stage
	a_nonlast_flows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !last_s2 |-> s2_go)
		else $error("non-last item stalled");

	// A first vertex that is not last leaves parity and hit clear
	a_first_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s2_go && first_s2 && !last_s2 |=> !parity_q && !hit_q)
		else $error("first vertex did not clear parity and hit");

	// An accepted item is held in the input register next cycle
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted item lost at input register");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ray-casting point-in-polygon unit. Vertex
// items are streamed in with random gaps while the result side stalls at
// random. Every accepted vertex is run through a bit-exact crossing-number
// tracker, and each returned inside_res is checked against the oldest
// pending prediction. Directed polygons cover extreme coordinates, vertex
// and edge hits, one-vertex polygons, a last vertex with no first and a
// point that moves mid-polygon. Random polygons follow under both
// settings of boundary_inside.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int          SETTLE_CYCLES = 8;
	localparam int          HANG_LIMIT    = 2000;
	localparam logic [31:0] MIN_C         = 32'h8000_0000;
	localparam logic [31:0] MAX_C         = 32'h7fff_ffff;

	typedef logic signed [33:0] pos_t;
	typedef logic signed [67:0] cross_t;
	typedef enum {SPREAD_NEAR, SPREAD_FULL, SPREAD_EDGE} spread_t;

	// Crossing-number tracker: mirrors the unit's polygon state and holds
	// the inside_res values still owed by the unit.
	class crossing_tracker;
		pos_t start_x, start_y, prior_x, prior_y;
		bit   parity;
		bit   on_boundary;
		bit   boundary_value;
		bit   expected_inside[$];
		int   failures;

		function new();
			start_x = 0;
			start_y = 0;
			prior_x = 0;
			prior_y = 0;
			parity = 1'b0;
			on_boundary = 1'b0;
			boundary_value = 1'b1;
			failures = 0;
		endfunction

		// Keep the low COORD_BITS bits, read as two's complement
		function pos_t coord_value(logic [pip_pkg::PORT_BITS-1:0] raw);
			logic signed [pip_pkg::PORT_BITS-1:0] t;
			t = raw << (pip_pkg::PORT_BITS - pip_pkg::COORD_BITS);
			return pos_t'(t >>> (pip_pkg::PORT_BITS - pip_pkg::COORD_BITS));
		endfunction

		// Test the edge from (jx,jy) to (ix,iy) against the point
		function void edge_test(pos_t ix, pos_t iy, pos_t jx, pos_t jy, pos_t px, pos_t py);
			cross_t a, b, c, d, cross_val;
			if (iy == py && (ix == px || (jy == py && (ix <= px || jx <= px)))) begin
				on_boundary = 1'b1;
				return;
			end
			if ((py < iy) != (py < jy)) begin
				a = ix - px;
				b = jy - py;
				c = iy - py;
				d = jx - px;
				cross_val = a * b - c * d;
				if (cross_val == 0)
					on_boundary = 1'b1;
				else if ((cross_val > 0) != (iy < jy))
					parity = ~parity;
			end
		endfunction

		function void note_vertex(logic [31:0] px_raw, logic [31:0] py_raw,
				logic [31:0] vx_raw, logic [31:0] vy_raw, bit first, bit last);
			pos_t px, py, vx, vy;
			px = coord_value(px_raw);
			py = coord_value(py_raw);
			vx = coord_value(vx_raw);
			vy = coord_value(vy_raw);
			if (first) begin
				parity = 1'b0;
				on_boundary = 1'b0;
				start_x = vx;
				start_y = vy;
			end else begin
				edge_test(vx, vy, prior_x, prior_y, px, py);
			end
			prior_x = vx;
			prior_y = vy;
			// Close the polygon and owe one result
			if (last) begin
				edge_test(start_x, start_y, vx, vy, px, py);
				expected_inside.push_back(on_boundary ? boundary_value : parity);
			end
		endfunction

		function void check_inside(bit got);
			bit want;
			if (expected_inside.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected result: inside_res %0d", got);
				return;
			end
			want = expected_inside.pop_front();
			if (got !== want) begin
				failures++;
				if (failures <= 10)
					$display("mismatch: inside_res expected %0d got %0d", want, got);
			end
		endfunction

		function int pending();
			return expected_inside.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] point_x, point_y, vertex_x, vertex_y;
	logic        first_vertex, last_vertex;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        inside_res;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        boundary_inside;

	crossing_tracker tracker = new();
	bit steady = 1'b0;
	int items_sent = 0;
	int idle_cycles = 0;

	point_in_polygon_ray_cast_unit DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.point_x        (point_x),
		.point_y        (point_y),
		.vertex_x       (vertex_x),
		.vertex_y       (vertex_y),
		.first_vertex   (first_vertex),
		.last_vertex    (last_vertex),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.inside_res     (inside_res),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.boundary_inside(boundary_inside)
	);

	always #1 clk = ~clk;

	// Stall the result side at random, except in the steady stretch
	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(99) >= 15);
	end

	// Watch all three channels; predict on input, check on output
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				tracker.boundary_value = boundary_inside;
			if (in_valid && in_ready)
				tracker.note_vertex(point_x, point_y, vertex_x, vertex_y,
					first_vertex, last_vertex);
			if (out_valid && out_ready)
				tracker.check_inside(inside_res);
		end
	end

	// End the run when no handshake happens for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == HANG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", HANG_LIMIT);
			$display("Verification failed");
			$finish;
		end
	end

	task automatic send_vertex(input logic [31:0] px, input logic [31:0] py,
			input logic [31:0] vx, input logic [31:0] vy, input bit first, input bit last);
		// Insert a random gap before the item
		if (!steady && $urandom_range(99) < 15) begin
			in_valid <= 1'b0;
			do @(posedge clk); while (!steady && $urandom_range(99) < 15);
		end
		in_valid <= 1'b1;
		point_x <= px;
		point_y <= py;
		vertex_x <= vx;
		vertex_y <= vy;
		first_vertex <= first;
		last_vertex <= last;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// Hold the input until every owed result is back, then let the pipe empty
	task automatic drain_results();
		in_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_boundary(input bit value);
		cfg_valid <= 1'b1;
		boundary_inside <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_square(input logic [31:0] px, input logic [31:0] py);
		send_vertex(px, py, -10, -10, 1'b1, 1'b0);
		send_vertex(px, py, 10, -10, 1'b0, 1'b0);
		send_vertex(px, py, 10, 10, 1'b0, 1'b0);
		send_vertex(px, py, -10, 10, 1'b0, 1'b1);
	endtask

	function automatic logic [31:0] pick_coord(spread_t spread);
		case (spread)
			SPREAD_NEAR: return $urandom_range(8) - 4;
			SPREAD_FULL: return $urandom();
			default: begin
				case ($urandom_range(3))
					0: return MIN_C + $urandom_range(3);
					1: return MAX_C - $urandom_range(3);
					2: return $urandom_range(3);
					default: return -$urandom_range(3);
				endcase
			end
		endcase
	endfunction

	// Mostly well-formed polygons; some with a roaming point or bad flags
	task automatic send_random_polygon();
		logic [31:0] vx[8], vy[8];
		logic [31:0] px, py;
		spread_t spread;
		int n, k, dx, dy, r;
		bit roam, broken, first, last;
		n = $urandom_range(1, 7);
		r = $urandom_range(99);
		spread = (r < 60) ? SPREAD_NEAR : (r < 85) ? SPREAD_FULL : SPREAD_EDGE;
		roam = ($urandom_range(9) == 0);
		broken = ($urandom_range(9) == 0);
		for (int i = 0; i < n; i++) begin
			vx[i] = pick_coord(spread);
			vy[i] = pick_coord(spread);
		end
		px = pick_coord(spread);
		py = pick_coord(spread);
		r = $urandom_range(99);
		// Place the point on an edge or on a vertex now and then
		if (n >= 2 && r < 15) begin
			k = $urandom_range(n - 2);
			dx = $urandom_range(6);
			dy = $urandom_range(6);
			dx -= 3;
			dy -= 3;
			vx[k + 1] = vx[k] + 2 * dx;
			vy[k + 1] = vy[k] + 2 * dy;
			px = vx[k] + dx;
			py = vy[k] + dy;
		end else if (r < 30) begin
			k = $urandom_range(n - 1);
			px = vx[k];
			py = vy[k];
		end
		for (int i = 0; i < n; i++) begin
			first = (i == 0);
			last = (i == n - 1);
			if (broken) begin
				first = ($urandom_range(2) == 0);
				last = ($urandom_range(3) == 0);
			end
			if (roam && i > 0) begin
				px = pick_coord(spread);
				py = pick_coord(spread);
			end
			send_vertex(px, py, vx[i], vy[i], first, last);
		end
		// Now and then wait for every result before going on
		if ($urandom_range(24) == 0)
			drain_results();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		point_x = '0;
		point_y = '0;
		vertex_x = '0;
		vertex_y = '0;
		first_vertex = 1'b0;
		last_vertex = 1'b0;
		cfg_valid = 1'b0;
		boundary_inside = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Last vertex with no first: edges run from the reset state
		send_vertex(1, 3, 5, 5, 1'b0, 1'b1);
		// One-vertex polygons: on the vertex, then off it
		send_vertex(7, -7, 7, -7, 1'b1, 1'b1);
		send_vertex(0, 0, 7, -7, 1'b1, 1'b1);
		// Square: inside, on a vertical edge, on a horizontal edge
		send_square(0, 0);
		send_square(10, 0);
		send_square(0, 10);
		// Full-range triangle: point inside, then far corner
		send_vertex(0, 0, MIN_C, MIN_C, 1'b1, 1'b0);
		send_vertex(0, 0, MAX_C, MIN_C, 1'b0, 1'b0);
		send_vertex(0, 0, 0, MAX_C, 1'b0, 1'b1);
		send_vertex(MAX_C, MAX_C, MIN_C, MIN_C, 1'b1, 1'b0);
		send_vertex(MAX_C, MAX_C, MAX_C, MIN_C, 1'b0, 1'b0);
		send_vertex(MAX_C, MAX_C, 0, MAX_C, 1'b0, 1'b1);
		// Point moves from item to item within one polygon
		send_vertex(1, 1, 0, 0, 1'b1, 1'b0);
		send_vertex(MIN_C, MAX_C, 8, 0, 1'b0, 1'b0);
		send_vertex(8, 0, 0, 8, 1'b0, 1'b1);
		drain_results();

		// Boundary hits report outside
		write_boundary(1'b0);
		while (items_sent < 180)
			send_random_polygon();
		drain_results();

		// Boundary hits report inside; run part of it with no idling
		write_boundary(1'b1);
		steady = 1'b1;
		while (items_sent < 290)
			send_random_polygon();
		steady = 1'b0;
		while (items_sent < 330)
			send_random_polygon();
		drain_results();

		write_boundary(1'b0);
		while (items_sent < 450)
			send_random_polygon();
		drain_results();

		if (tracker.failures == 0 && tracker.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== point_in_polygon_ray_cast_unit.f =====
rtl/pip_pkg.sv
rtl/pip_edge_test.sv
rtl/point_in_polygon_ray_cast_unit.sv
test/tb_top.sv
